[rtl/srgi_pkg.sv]
// Shared types, constants and sequencer states for the ring grid interpolator.
// Used by every module and interface under rtl/.
package srgi_pkg;

   localparam int RING_MAX    = 4096;
   localparam int GRID_MAX    = 32;

   localparam int SITE_W      = $clog2(RING_MAX);
   localparam int CFG_W       = SITE_W + 1;
   localparam int POS_W       = CFG_W + 1;
   localparam int SAMPLE_W    = 32;
   localparam int DIFF_W      = SAMPLE_W + 1;
   localparam int PROD_W      = DIFF_W + SITE_W;
   localparam int QUOT_W      = DIFF_W;
   localparam int STEPS_W     = $clog2(QUOT_W + 1);
   localparam int CNT_W       = $clog2(GRID_MAX + 1);
   localparam int INDEX_W     = 5;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int ADDR_W      = 3;
   localparam int DATA_W      = 32;

   localparam logic [CFG_W-1:0] RING_RESET = CFG_W'(1024);
   localparam logic [CFG_W-1:0] STEP_RESET = CFG_W'(128);

   typedef enum logic {
      REG_RING_SIZE = 1'b0,
      REG_GRID_STEP = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [CFG_W-1:0] ring;
      logic [CFG_W-1:0] step;
   } cfg_type;

   typedef struct packed {
      logic [SITE_W-1:0]   site;
      logic [SAMPLE_W-1:0] sample;
      logic                final_site;
      logic                first;
   } job_type;

   typedef struct packed {
      logic [INDEX_W-1:0]  grid_index;
      logic [SAMPLE_W-1:0] grid_value;
      logic                run_end;
   } result_type;

   typedef struct packed {
      logic               start;
      logic [CFG_W-1:0]   rem_init;
      logic [PROD_W-1:0]  num;
      logic [STEPS_W-1:0] steps;
      logic [CFG_W-1:0]   divisor;
   } div_req_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [QUOT_W-1:0] quot;
      logic [CFG_W-1:0]  rem;
   } div_rsp_type;

   typedef enum logic [3:0] {
      B_IDLE,
      B_SITE_MOD,
      B_SEG_START,
      B_SEG_MOD0,
      B_SEG_MOD1,
      B_SEG_DIVK,
      B_SEG_MULK,
      B_SEG_INIT,
      B_PT_CHECK,
      B_PT_MUL,
      B_PT_START,
      B_PT_DIV,
      B_PT_SUM,
      B_PT_EMIT,
      B_SEG_END,
      B_ITEM_END
   } back_state_type;

endpackage

[rtl/srgi_if.sv]
// Valid/ready channel interfaces for observations and grid results.
// Depends on srgi_pkg for field widths.
interface srgi_req_if import srgi_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [SITE_W-1:0]          site;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       final_site;

   modport source (output valid, site, sample, final_site, input ready);
   modport sink (input valid, site, sample, final_site, output ready);
endinterface

interface srgi_rsp_if import srgi_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [INDEX_W-1:0]         grid_index;
   logic signed [SAMPLE_W-1:0] grid_value;
   logic                       run_end;

   modport source (output valid, grid_index, grid_value, run_end, input ready);
   modport sink (input valid, grid_index, grid_value, run_end, output ready);
endinterface

[rtl/srgi_front.sv]
// Front end: accepts observations, tags the first of each set, stages them for the queue.
// Depends on srgi_pkg and srgi_req_if.
module srgi_front import srgi_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   srgi_req_if.sink    req_chan,
   output logic        push_valid,
   input  logic        push_ready,
   output job_type     push_job
);

   logic    stage_valid_ff, stage_valid_in;
   logic    have_first_ff, have_first_in;
   job_type stage_ff, stage_in;
   logic    accept;

   assign req_chan.ready = !stage_valid_ff || push_ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign push_valid     = stage_valid_ff;
   assign push_job       = stage_ff;

   always_comb begin
      stage_valid_in = stage_valid_ff && !push_ready;
      stage_in       = stage_ff;
      have_first_in  = have_first_ff;
      if (accept) begin
         stage_valid_in      = 1'b1;
         stage_in.site       = req_chan.site;
         stage_in.sample     = req_chan.sample;
         stage_in.final_site = req_chan.final_site;
         stage_in.first      = !have_first_ff;
         have_first_in       = !req_chan.final_site;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         have_first_ff  <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         have_first_ff  <= have_first_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

endmodule

[rtl/srgi_queue.sv]
// Short job queue between the front end and the segment sequencer.
// Depends on srgi_pkg.
module srgi_queue import srgi_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  job_type push_job,
   output logic    pop_valid,
   input  logic    pop_ready,
   output job_type pop_job
);

   job_type           entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              push, pop;

   assign push_ready = count_ff != QCNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_job    = entries_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

[rtl/srgi_div.sv]
// Shared restoring divider, one quotient bit per cycle, dividend consumed MSB first.
// Depends on srgi_pkg for the request and response structs.
module srgi_div import srgi_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [STEPS_W-1:0] cnt_ff, cnt_in;
   logic [CFG_W-1:0]   rem_ff, rem_in;
   logic [PROD_W-1:0]  num_ff, num_in;
   logic [QUOT_W-1:0]  quot_ff, quot_in;
   logic [CFG_W-1:0]   divisor_ff, divisor_in;
   logic [CFG_W:0]     trial;
   logic               fits;

   assign trial = {rem_ff, num_ff[PROD_W-1]};
   assign fits  = trial >= {1'b0, divisor_ff};

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;
   assign rsp.rem  = rem_ff;

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      num_in     = num_ff;
      quot_in    = quot_ff;
      divisor_in = divisor_ff;
      if (req.start) begin
         busy_in    = 1'b1;
         cnt_in     = req.steps;
         rem_in     = req.rem_init;
         num_in     = req.num;
         quot_in    = '0;
         divisor_in = req.divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? CFG_W'(trial - {1'b0, divisor_ff}) : trial[CFG_W-1:0];
         num_in  = {num_ff[PROD_W-2:0], 1'b0};
         quot_in = {quot_ff[QUOT_W-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == STEPS_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      num_ff     <= num_in;
      quot_ff    <= quot_in;
      divisor_ff <= divisor_in;
   end

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      req.start |-> !busy_ff)
      else $error("divider started while busy");

   a_div_rem_bound: assert property (@(posedge clock) disable iff (reset)
      req.start |-> (req.rem_init < req.divisor))
      else $error("divider partial remainder not below divisor");

   a_div_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider done while still busy");

endmodule

[rtl/srgi_back.sv]
// Back end: per-job segment sequencer, grid point interpolation and result output register.
// Depends on srgi_pkg, srgi_rsp_if and a shared srgi_div instance at the top level.
module srgi_back import srgi_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        job_valid,
   output logic        job_ready,
   input  job_type     job,
   output div_req_type div_req,
   input  div_rsp_type div_rsp,
   srgi_rsp_if.source  rsp_chan
);

   back_state_type      state_ff, state_in;
   job_type             job_ff, job_in;
   logic [SITE_W-1:0]   site_m_ff, site_m_in;
   logic [SITE_W-1:0]   first_site_ff, first_site_in;
   logic [SAMPLE_W-1:0] first_sample_ff, first_sample_in;
   logic [SITE_W-1:0]   prev_site_ff, prev_site_in;
   logic [SAMPLE_W-1:0] prev_sample_ff, prev_sample_in;
   logic                seg_wrap_ff, seg_wrap_in;
   logic [SITE_W-1:0]   src0_ff, src0_in;
   logic [SITE_W-1:0]   src1_ff, src1_in;
   logic [SAMPLE_W-1:0] z0_ff, z0_in;
   logic [SAMPLE_W-1:0] z1_ff, z1_in;
   logic [DIFF_W-1:0]   diff_ff, diff_in;
   logic [DIFF_W-1:0]   mag_ff, mag_in;
   logic                neg_ff, neg_in;
   logic [SITE_W-1:0]   n0_ff, n0_in;
   logic [SITE_W-1:0]   gap_ff, gap_in;
   logic [POS_W-1:0]    n1_ff, n1_in;
   logic [CFG_W-1:0]    kq_ff, kq_in;
   logic [POS_W-1:0]    n_ff, n_in;
   logic [SITE_W-1:0]   m_ff, m_in;
   logic [SITE_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [SITE_W-1:0]   t_ff, t_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [QUOT_W-1:0]   sq_ff, sq_in;
   logic [SAMPLE_W-1:0] v_ff, v_in;
   result_type          hold_ff, hold_in;
   logic                hold_valid_ff, hold_valid_in;
   result_type          out_ff, out_in;
   logic                out_valid_ff, out_valid_in;

   logic [2*CFG_W-1:0]  kmul;
   logic [PROD_W-1:0]   pmul;
   logic [SITE_W-1:0]   s1m;
   logic [POS_W-1:0]    mm;
   logic                out_free;

   assign kmul     = kq_ff * cfg.step;
   assign pmul     = mag_ff * t_ff;
   assign s1m      = div_rsp.rem[SITE_W-1:0];
   assign mm       = POS_W'(m_ff) + POS_W'(cfg.step);
   assign out_free = !out_valid_ff || rsp_chan.ready;

   assign job_ready           = state_ff == B_IDLE;
   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.grid_index = out_ff.grid_index;
   assign rsp_chan.grid_value = out_ff.grid_value;
   assign rsp_chan.run_end    = out_ff.run_end;

   always_comb begin
      state_in        = state_ff;
      job_in          = job_ff;
      site_m_in       = site_m_ff;
      first_site_in   = first_site_ff;
      first_sample_in = first_sample_ff;
      prev_site_in    = prev_site_ff;
      prev_sample_in  = prev_sample_ff;
      seg_wrap_in     = seg_wrap_ff;
      src0_in         = src0_ff;
      src1_in         = src1_ff;
      z0_in           = z0_ff;
      z1_in           = z1_ff;
      diff_in         = diff_ff;
      mag_in          = mag_ff;
      neg_in          = neg_ff;
      n0_in           = n0_ff;
      gap_in          = gap_ff;
      n1_in           = n1_ff;
      kq_in           = kq_ff;
      n_in            = n_ff;
      m_in            = m_ff;
      idx_in          = idx_ff;
      cnt_in          = cnt_ff;
      t_in            = t_ff;
      prod_in         = prod_ff;
      sq_in           = sq_ff;
      v_in            = v_ff;
      hold_in         = hold_ff;
      hold_valid_in   = hold_valid_ff;
      out_in          = out_ff;
      out_valid_in    = out_valid_ff && !rsp_chan.ready;
      div_req         = '0;

      unique case (state_ff)
         B_IDLE: begin
            if (job_valid) begin
               job_in           = job;
               div_req.start    = 1'b1;
               div_req.num      = {job.site, (PROD_W - SITE_W)'(0)};
               div_req.steps    = STEPS_W'(SITE_W);
               div_req.divisor  = cfg.ring;
               state_in         = B_SITE_MOD;
            end
         end
         B_SITE_MOD: begin
            if (div_rsp.done) begin
               site_m_in      = s1m;
               prev_site_in   = s1m;
               prev_sample_in = job_ff.sample;
               if (job_ff.first) begin
                  first_site_in   = s1m;
                  first_sample_in = job_ff.sample;
                  state_in        = B_ITEM_END;
               end else begin
                  src0_in     = prev_site_ff;
                  z0_in       = prev_sample_ff;
                  src1_in     = s1m;
                  z1_in       = job_ff.sample;
                  seg_wrap_in = 1'b0;
                  state_in    = B_SEG_START;
               end
            end
         end
         B_SEG_START: begin
            diff_in         = {z1_ff[SAMPLE_W-1], z1_ff} - {z0_ff[SAMPLE_W-1], z0_ff};
            div_req.start   = 1'b1;
            div_req.num     = {src0_ff, (PROD_W - SITE_W)'(0)};
            div_req.steps   = STEPS_W'(SITE_W);
            div_req.divisor = cfg.ring;
            state_in        = B_SEG_MOD0;
         end
         B_SEG_MOD0: begin
            neg_in = diff_ff[DIFF_W-1];
            mag_in = diff_ff[DIFF_W-1] ? (~diff_ff + 1'b1) : diff_ff;
            if (div_rsp.done) begin
               n0_in           = s1m;
               div_req.start   = 1'b1;
               div_req.num     = {src1_ff, (PROD_W - SITE_W)'(0)};
               div_req.steps   = STEPS_W'(SITE_W);
               div_req.divisor = cfg.ring;
               state_in        = B_SEG_MOD1;
            end
         end
         B_SEG_MOD1: begin
            if (div_rsp.done) begin
               if (s1m >= n0_ff) begin
                  gap_in = s1m - n0_ff;
               end else begin
                  gap_in = SITE_W'(POS_W'(s1m) + POS_W'(cfg.ring) - POS_W'(n0_ff));
               end
               n1_in = POS_W'(n0_ff) + POS_W'(gap_in);
               if (gap_in == '0) begin
                  state_in = B_SEG_END;
               end else begin
                  div_req.start   = 1'b1;
                  div_req.num     = {n0_ff, (PROD_W - SITE_W)'(0)};
                  div_req.steps   = STEPS_W'(SITE_W);
                  div_req.divisor = cfg.step;
                  state_in        = B_SEG_DIVK;
               end
            end
         end
         B_SEG_DIVK: begin
            if (div_rsp.done) begin
               kq_in    = CFG_W'(div_rsp.quot[SITE_W-1:0]) + CFG_W'(div_rsp.rem != '0);
               state_in = B_SEG_MULK;
            end
         end
         B_SEG_MULK: begin
            n_in     = kmul[POS_W-1:0];
            state_in = B_SEG_INIT;
         end
         B_SEG_INIT: begin
            cnt_in = '0;
            if (n_ff >= POS_W'(cfg.ring)) begin
               m_in   = SITE_W'(n_ff - POS_W'(cfg.ring));
               idx_in = '0;
            end else begin
               m_in   = n_ff[SITE_W-1:0];
               idx_in = kq_ff[SITE_W-1:0];
            end
            state_in = B_PT_CHECK;
         end
         B_PT_CHECK: begin
            if (n_ff < n1_ff && cnt_ff < CNT_W'(GRID_MAX)) begin
               t_in     = SITE_W'(n_ff - POS_W'(n0_ff));
               state_in = B_PT_MUL;
            end else begin
               state_in = B_SEG_END;
            end
         end
         B_PT_MUL: begin
            prod_in  = pmul;
            state_in = B_PT_START;
         end
         B_PT_START: begin
            div_req.start    = 1'b1;
            div_req.rem_init = CFG_W'(prod_ff[PROD_W-1:QUOT_W]);
            div_req.num      = {prod_ff[QUOT_W-1:0], (PROD_W - QUOT_W)'(0)};
            div_req.steps    = STEPS_W'(QUOT_W);
            div_req.divisor  = CFG_W'(gap_ff);
            state_in         = B_PT_DIV;
         end
         B_PT_DIV: begin
            if (div_rsp.done) begin
               sq_in    = neg_ff ? (~div_rsp.quot + 1'b1) : div_rsp.quot;
               state_in = B_PT_SUM;
            end
         end
         B_PT_SUM: begin
            v_in     = z0_ff + sq_ff[SAMPLE_W-1:0];
            state_in = B_PT_EMIT;
         end
         B_PT_EMIT: begin
            if (!hold_valid_ff || out_free) begin
               if (hold_valid_ff) begin
                  out_in         = hold_ff;
                  out_in.run_end = 1'b0;
                  out_valid_in   = 1'b1;
               end
               hold_in.grid_index = idx_ff[INDEX_W-1:0];
               hold_in.grid_value = v_ff;
               hold_in.run_end    = 1'b0;
               hold_valid_in      = 1'b1;
               n_in               = n_ff + POS_W'(cfg.step);
               cnt_in             = cnt_ff + 1'b1;
               if (mm >= POS_W'(cfg.ring)) begin
                  m_in   = SITE_W'(mm - POS_W'(cfg.ring));
                  idx_in = '0;
               end else begin
                  m_in   = mm[SITE_W-1:0];
                  idx_in = idx_ff + 1'b1;
               end
               state_in = B_PT_CHECK;
            end
         end
         B_SEG_END: begin
            if (!seg_wrap_ff && job_ff.final_site) begin
               src0_in     = site_m_ff;
               z0_in       = job_ff.sample;
               src1_in     = first_site_ff;
               z1_in       = first_sample_ff;
               seg_wrap_in = 1'b1;
               state_in    = B_SEG_START;
            end else begin
               state_in = B_ITEM_END;
            end
         end
         B_ITEM_END: begin
            if (!hold_valid_ff) begin
               state_in = B_IDLE;
            end else if (out_free) begin
               out_in         = hold_ff;
               out_in.run_end = 1'b1;
               out_valid_in   = 1'b1;
               hold_valid_in  = 1'b0;
               state_in       = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= B_IDLE;
         hold_valid_ff   <= 1'b0;
         out_valid_ff    <= 1'b0;
         first_site_ff   <= '0;
         first_sample_ff <= '0;
         prev_site_ff    <= '0;
         prev_sample_ff  <= '0;
      end else begin
         state_ff        <= state_in;
         hold_valid_ff   <= hold_valid_in;
         out_valid_ff    <= out_valid_in;
         first_site_ff   <= first_site_in;
         first_sample_ff <= first_sample_in;
         prev_site_ff    <= prev_site_in;
         prev_sample_ff  <= prev_sample_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      site_m_ff   <= site_m_in;
      seg_wrap_ff <= seg_wrap_in;
      src0_ff     <= src0_in;
      src1_ff     <= src1_in;
      z0_ff       <= z0_in;
      z1_ff       <= z1_in;
      diff_ff     <= diff_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      n0_ff       <= n0_in;
      gap_ff      <= gap_in;
      n1_ff       <= n1_in;
      kq_ff       <= kq_in;
      n_ff        <= n_in;
      m_ff        <= m_in;
      idx_ff      <= idx_in;
      cnt_ff      <= cnt_in;
      t_ff        <= t_in;
      prod_ff     <= prod_in;
      sq_ff       <= sq_in;
      v_ff        <= v_in;
      hold_ff     <= hold_in;
      out_ff      <= out_in;
   end

   a_offset_in_gap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_PT_MUL) |-> (t_ff < gap_ff))
      else $error("grid offset not inside segment gap");

   a_idle_hold_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_IDLE) |-> !hold_valid_ff)
      else $error("held result left behind at end of transaction");

   a_emit_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_PT_EMIT && hold_valid_ff && !out_free) |=> (state_ff == B_PT_EMIT))
      else $error("grid point advanced while output blocked");

endmodule

[rtl/sparse_to_grid_ring_interpolator_unit.sv]
// Top level of the ring grid interpolator: register port, front end, job queue,
// shared divider and segment sequencer. Depends on srgi_pkg and srgi_if.
//
// Observations enter on req_chan; each one yields the interpolated coarse grid
// points between the previous observation and itself, plus the wrap segment back
// to the first observation when final_site is set, on rsp_chan with run_end on
// the last result of each transaction. One observation is worked at a time by a
// sequencer built around a single restoring divider that resolves one quotient
// bit per cycle. The front end and a two-entry queue take up to three further
// observations meanwhile.
// The user writes ring_size (byte address 0) and grid_step (byte address 4)
// over the APB port only while no transaction is in flight; the block itself
// does not enforce this.
module sparse_to_grid_ring_interpolator_unit import srgi_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   srgi_req_if.sink          req_chan,
   srgi_rsp_if.source        rsp_chan,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   logic [CFG_W-1:0] ring_size_ff, ring_size_in;
   logic [CFG_W-1:0] grid_step_ff, grid_step_in;
   reg_index_type    reg_sel;
   logic             cfg_write;
   cfg_type          cfg;

   logic             push_valid, push_ready;
   job_type          push_job;
   logic             job_valid, job_ready;
   job_type          job;
   div_req_type      div_req;
   div_rsp_type      div_rsp;

   assign pready    = 1'b1;
   assign reg_sel   = reg_index_type'(paddr[2]);
   assign cfg_write = psel && penable && pwrite;

   always_comb begin
      ring_size_in = ring_size_ff;
      grid_step_in = grid_step_ff;
      prdata       = '0;
      unique case (reg_sel)
         REG_RING_SIZE: begin
            prdata = DATA_W'(ring_size_ff);
            if (cfg_write) begin
               ring_size_in = pwdata[CFG_W-1:0];
            end
         end
         REG_GRID_STEP: begin
            prdata = DATA_W'(grid_step_ff);
            if (cfg_write) begin
               grid_step_in = pwdata[CFG_W-1:0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_comb begin
      if (ring_size_ff == '0) begin
         cfg.ring = CFG_W'(1);
      end else if (ring_size_ff > CFG_W'(RING_MAX)) begin
         cfg.ring = CFG_W'(RING_MAX);
      end else begin
         cfg.ring = ring_size_ff;
      end
      cfg.step = (grid_step_ff == '0) ? CFG_W'(1) : grid_step_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_size_ff <= RING_RESET;
         grid_step_ff <= STEP_RESET;
      end else begin
         ring_size_ff <= ring_size_in;
         grid_step_ff <= grid_step_in;
      end
   end

   srgi_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job)
   );

   srgi_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (job_valid),
      .pop_ready  (job_ready),
      .pop_job    (job)
   );

   srgi_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   srgi_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .job_valid (job_valid),
      .job_ready (job_ready),
      .job       (job),
      .div_req   (div_req),
      .div_rsp   (div_rsp),
      .rsp_chan  (rsp_chan)
   );

endmodule
